### src/range_max_drawdown_query_top_macros.svh
// Assertion helpers for the range drawdown query block.
`ifndef RANGE_MAX_DRAWDOWN_QUERY_TOP_MACROS_SVH
`define RANGE_MAX_DRAWDOWN_QUERY_TOP_MACROS_SVH
`ifndef SYNTHESIS
// implication or plain property, checked every clock outside reset
`define RMDQ_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rmdq assertion failed");
// condition that must never hold outside reset
`define RMDQ_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rmdq assertion failed");
`else
`define RMDQ_ASSERT(name, clk, rst_n, prop)
`define RMDQ_ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

### src/rmdq_pkg.sv
`default_nettype none
package rmdq_pkg;

  localparam int unsigned VAL_W            = 31;
  localparam int unsigned IDX_W            = 10;
  localparam int unsigned CNT_W            = 11;
  localparam int unsigned MODE_W           = 2;
  localparam int unsigned MAX_ELEMENTS_DEF = 1024;
  localparam int unsigned VALUE_BITS_DEF   = 31;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_BUILD = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  // one tree node: max, min, largest drop, largest relative drop rn/rd
  typedef struct packed {
    logic             empty;
    logic [VAL_W-1:0] mx;
    logic [VAL_W-1:0] mn;
    logic [VAL_W-1:0] drop;
    logic [VAL_W-1:0] rn;
    logic [VAL_W-1:0] rd;
  } agg_t;

  localparam agg_t EMPTY_AGG = '{empty: 1'b1, mx: '0, mn: '0, drop: '0, rn: '0,
                                 rd: VAL_W'(1)};

endpackage
`default_nettype wire

### src/rmdq_in_if.sv
`default_nettype none
interface rmdq_in_if import rmdq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [IDX_W-1:0]  index;
  logic [VAL_W-1:0]  value;
  logic [IDX_W-1:0]  left;
  logic [IDX_W-1:0]  right;

  modport source (output valid, mode, index, value, left, right, input ready);
  modport sink   (input valid, mode, index, value, left, right, output ready);
endinterface
`default_nettype wire

### src/rmdq_out_if.sv
`default_nettype none
interface rmdq_out_if import rmdq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] max_drop;
  logic [VAL_W-1:0] ratio_num;
  logic [VAL_W-1:0] ratio_den;
  logic             range_error;

  modport source (output valid, max_drop, ratio_num, ratio_den, range_error, input ready);
  modport sink   (input valid, max_drop, ratio_num, ratio_den, range_error, output ready);
endinterface
`default_nettype wire

### src/rmdq_cfg_if.sv
`default_nettype none
interface rmdq_cfg_if import rmdq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

### src/rmdq_mem.sv
`default_nettype none
module rmdq_mem import rmdq_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  localparam int unsigned POS_W       = $clog2(MAX_ELEMENTS),
  localparam int unsigned NODES       = 4 * MAX_ELEMENTS,
  localparam int unsigned NODE_W      = $clog2(NODES)
) (
  input  logic              clk_i,
  input  logic              val_we_i,
  input  logic [POS_W-1:0]  val_waddr_i,
  input  logic [VAL_W-1:0]  val_wdata_i,
  input  logic [POS_W-1:0]  val_raddr_i,
  output logic [VAL_W-1:0]  val_rdata_o,
  input  logic              node_we_i,
  input  logic [NODE_W-1:0] node_waddr_i,
  input  agg_t              node_wdata_i,
  input  logic [NODE_W-1:0] node_raddr_i,
  output agg_t              node_rdata_o
);

  logic [VAL_W-1:0] val_mem [MAX_ELEMENTS];
  agg_t             node_mem [NODES];

  // element values: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (val_we_i) begin
      val_mem[val_waddr_i] <= val_wdata_i;
    end
    val_rdata_o <= val_mem[val_raddr_i];
  end

  // tree nodes: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (node_we_i) begin
      node_mem[node_waddr_i] <= node_wdata_i;
    end
    node_rdata_o <= node_mem[node_raddr_i];
  end

endmodule
`default_nettype wire

### src/rmdq_merge.sv
`default_nettype none
module rmdq_merge import rmdq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  agg_t a_i,
  input  agg_t b_i,
  output logic done_o,
  output agg_t c_o
);

  localparam int unsigned KW = $clog2(VAL_W);

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_GCD, S_DIV, S_MULA, S_MULB, S_PICK, S_DONE
  } state_e;

  state_e             state_q;
  agg_t               a_q, b_q, c_q;
  logic [VAL_W-1:0]   d_q, u_q, v_q, g_q;
  logic [KW-1:0]      k_q, cnt_q;
  logic [VAL_W-1:0]   qd_q, qm_q, r1_q, r2_q;
  logic [VAL_W-1:0]   cn_q, cd_q, cand_n_q, cand_d_q;
  logic               second_q;
  logic [2*VAL_W-1:0] p1_q, p2_q;

  logic [VAL_W-1:0]   d_w, drop_ab, drop_w;
  logic [VAL_W:0]     t1, t2, s1, s2;
  logic               ge1, ge2;
  logic [VAL_W-1:0]   qd_d, qm_d;
  logic [VAL_W-1:0]   mul_x, mul_y;
  logic [2*VAL_W-1:0] prod;

  // cross drop of left max over right min, and the three-way max drop
  always_comb begin
    d_w     = (a_q.mx > b_q.mn) ? a_q.mx - b_q.mn : '0;
    drop_ab = (a_q.drop > b_q.drop) ? a_q.drop : b_q.drop;
    drop_w  = (d_w > drop_ab) ? d_w : drop_ab;
  end

  // one restoring divide step for both quotients by the common divisor
  always_comb begin
    t1   = {r1_q, qd_q[VAL_W-1]};
    t2   = {r2_q, qm_q[VAL_W-1]};
    s1   = t1 - {1'b0, g_q};
    s2   = t2 - {1'b0, g_q};
    ge1  = (t1 >= {1'b0, g_q});
    ge2  = (t2 >= {1'b0, g_q});
    qd_d = {qd_q[VAL_W-2:0], ge1};
    qm_d = {qm_q[VAL_W-2:0], ge2};
  end

  // shared multiplier for the cross-multiplied fraction compare
  always_comb begin
    mul_x = (state_q == S_MULA) ? c_q.rn : cand_n_q;
    mul_y = (state_q == S_MULA) ? cand_d_q : c_q.rd;
    prod  = (2*VAL_W)'(mul_x) * (2*VAL_W)'(mul_y);
  end

  assign done_o = (state_q == S_DONE);
  assign c_o    = c_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      a_q      <= EMPTY_AGG;
      b_q      <= EMPTY_AGG;
      c_q      <= EMPTY_AGG;
      d_q      <= '0;
      u_q      <= '0;
      v_q      <= '0;
      g_q      <= '0;
      k_q      <= '0;
      cnt_q    <= '0;
      qd_q     <= '0;
      qm_q     <= '0;
      r1_q     <= '0;
      r2_q     <= '0;
      cn_q     <= '0;
      cd_q     <= '0;
      cand_n_q <= '0;
      cand_d_q <= '0;
      second_q <= 1'b0;
      p1_q     <= '0;
      p2_q     <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            a_q     <= a_i;
            b_q     <= b_i;
            state_q <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (a_q.empty) begin
            c_q     <= b_q;
            state_q <= S_DONE;
          end else if (b_q.empty) begin
            c_q     <= a_q;
            state_q <= S_DONE;
          end else begin
            c_q.empty <= 1'b0;
            c_q.mx    <= (a_q.mx > b_q.mx) ? a_q.mx : b_q.mx;
            c_q.mn    <= (a_q.mn < b_q.mn) ? a_q.mn : b_q.mn;
            c_q.drop  <= drop_w;
            c_q.rn    <= a_q.rn;
            c_q.rd    <= a_q.rd;
            cand_n_q  <= b_q.rn;
            cand_d_q  <= b_q.rd;
            second_q  <= 1'b0;
            cn_q      <= '0;
            cd_q      <= VAL_W'(1);
            d_q       <= d_w;
            u_q       <= d_w;
            v_q       <= a_q.mx;
            k_q       <= '0;
            state_q   <= (a_q.mx == '0 || d_w == '0) ? S_MULA : S_GCD;
          end
        end
        // binary gcd, one step a cycle
        S_GCD: begin
          if (u_q == '0 || v_q == '0) begin
            g_q     <= VAL_W'((u_q | v_q) << k_q);
            qd_q    <= d_q;
            qm_q    <= a_q.mx;
            r1_q    <= '0;
            r2_q    <= '0;
            cnt_q   <= '0;
            state_q <= S_DIV;
          end else if (!u_q[0] && !v_q[0]) begin
            u_q <= u_q >> 1;
            v_q <= v_q >> 1;
            k_q <= k_q + KW'(1);
          end else if (!u_q[0]) begin
            u_q <= u_q >> 1;
          end else if (!v_q[0]) begin
            v_q <= v_q >> 1;
          end else if (u_q > v_q) begin
            u_q <= u_q - v_q;
          end else begin
            v_q <= v_q - u_q;
          end
        end
        // reduce the cross fraction, one quotient bit a cycle
        S_DIV: begin
          r1_q  <= ge1 ? s1[VAL_W-1:0] : t1[VAL_W-1:0];
          r2_q  <= ge2 ? s2[VAL_W-1:0] : t2[VAL_W-1:0];
          qd_q  <= qd_d;
          qm_q  <= qm_d;
          cnt_q <= cnt_q + KW'(1);
          if (cnt_q == KW'(VAL_W - 1)) begin
            cn_q    <= qd_d;
            cd_q    <= qm_d;
            state_q <= S_MULA;
          end
        end
        S_MULA: begin
          p1_q    <= prod;
          state_q <= S_MULB;
        end
        S_MULB: begin
          p2_q    <= prod;
          state_q <= S_PICK;
        end
        // keep the earlier ratio on a tie
        S_PICK: begin
          if (p1_q < p2_q) begin
            c_q.rn <= cand_n_q;
            c_q.rd <= cand_d_q;
          end
          if (!second_q) begin
            second_q <= 1'b1;
            cand_n_q <= cn_q;
            cand_d_q <= cd_q;
            state_q  <= S_MULA;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DONE:  state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### src/range_max_drawdown_query_top.sv
// Channel  Dir  Payload                                        Accept
// in_i     in   mode, index, value, left, right                valid & ready
// out_o    out  max_drop, ratio_num, ratio_den, range_error    valid & ready
// cfg_i    in   data (element_count)                           valid & ready
//
// Build runs one merge per inner node; a query, one per non-empty covered node.
// A merge in the shared gcd/divide/multiply unit skips the gcd and divide steps
// when the cross drop or the left max is zero, and all steps when a side is empty.
// After reset a clearing pass zeroes the value store and empties the 4 * MAX_ELEMENTS
// node store entries; no item is accepted during it.
// A finished result waits in the output register; the next item is taken meanwhile.
`default_nettype none
`include "range_max_drawdown_query_top_macros.svh"
module range_max_drawdown_query_top import rmdq_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int unsigned VALUE_BITS   = VALUE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rmdq_in_if.sink    in_i,
  rmdq_out_if.source out_o,
  rmdq_cfg_if.sink   cfg_i
);

  localparam int unsigned POS_W   = $clog2(MAX_ELEMENTS);
  localparam int unsigned NODES   = 4 * MAX_ELEMENTS;
  localparam int unsigned NODE_W  = $clog2(NODES);
  localparam int unsigned STACK_D = 2 * POS_W + 4;
  localparam int unsigned STK_IW  = $clog2(STACK_D);
  localparam int unsigned SP_W    = $clog2(STACK_D + 1);
  localparam logic [VAL_W-1:0] VAL_MASK = VAL_W'((64'(1) << VALUE_BITS) - 64'(1));

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_POP, ST_VISIT, ST_PUSH_R, ST_PUSH_L,
    ST_LEAF, ST_RD_R, ST_NODE, ST_MRG, ST_EMIT
  } state_e;

  state_e            state_q;
  logic [NODE_W-1:0] clr_q;
  logic [CNT_W-1:0]  count_q;
  logic [SP_W-1:0]   sp_q;
  logic              build_q;
  logic [NODE_W-1:0] cur_p_q;
  logic [POS_W-1:0]  cur_l_q, cur_r_q;
  logic              cur_ph_q;
  logic [IDX_W-1:0]  qa_q, qb_q;
  agg_t              acc_q, ma_q;
  logic [VAL_W-1:0]  res_drop_q, res_rn_q, res_rd_q;
  logic              res_err_q;
  logic              out_valid_q;
  logic [VAL_W-1:0]  out_drop_q, out_rn_q, out_rd_q;
  logic              out_err_q;

  logic [NODE_W-1:0] stk_p_q  [STACK_D];
  logic [POS_W-1:0]  stk_l_q  [STACK_D];
  logic [POS_W-1:0]  stk_r_q  [STACK_D];
  logic              stk_ph_q [STACK_D];

  // effective count and request decode
  logic [31:0]       n_eff;
  logic [POS_W-1:0]  last_w;
  logic [VAL_W-1:0]  val_masked;
  logic              accept, bad_range, start_walk;
  mode_e             mode_w;

  always_comb begin
    if (count_q == '0) begin
      n_eff = 32'd1;
    end else if (32'(count_q) > MAX_ELEMENTS) begin
      n_eff = MAX_ELEMENTS;
    end else begin
      n_eff = 32'(count_q);
    end
    last_w     = POS_W'(n_eff - 32'd1);
    val_masked = in_i.value & VAL_MASK;
    mode_w     = mode_e'(in_i.mode);
    accept     = in_i.valid && (state_q == ST_IDLE);
    bad_range  = (in_i.left > in_i.right) || (32'(in_i.right) >= n_eff);
    start_walk = accept && ((mode_w == MODE_BUILD) || (mode_w == MODE_QUERY && !bad_range));
  end

  // node geometry
  logic [POS_W-1:0]  mid_w;
  logic [NODE_W-1:0] lc_w, rc_w;
  logic              covered, disjoint;

  always_comb begin
    mid_w    = cur_l_q + ((cur_r_q - cur_l_q) >> 1);
    lc_w     = {cur_p_q[NODE_W-2:0], 1'b0};
    rc_w     = {cur_p_q[NODE_W-2:0], 1'b1};
    covered  = (32'(qa_q) <= 32'(cur_l_q)) && (32'(cur_r_q) <= 32'(qb_q));
    disjoint = (32'(qb_q) < 32'(cur_l_q)) || (32'(cur_r_q) < 32'(qa_q));
  end

  // traversal stack push selection
  logic              push_en, pop_en;
  logic [NODE_W-1:0] push_p;
  logic [POS_W-1:0]  push_l, push_r;
  logic              push_ph;

  always_comb begin
    push_en = 1'b0;
    push_p  = cur_p_q;
    push_l  = cur_l_q;
    push_r  = cur_r_q;
    push_ph = 1'b0;
    case (state_q)
      ST_IDLE: begin
        push_en = start_walk;
        push_p  = NODE_W'(1);
        push_l  = '0;
        push_r  = last_w;
      end
      ST_VISIT: begin
        push_en = build_q && (cur_l_q != cur_r_q) && !cur_ph_q;
        push_ph = 1'b1;
      end
      ST_PUSH_R: begin
        push_en = 1'b1;
        push_p  = rc_w;
        push_l  = mid_w + POS_W'(1);
      end
      ST_PUSH_L: begin
        push_en = 1'b1;
        push_p  = lc_w;
        push_r  = mid_w;
      end
      default: ;
    endcase
    pop_en = (state_q == ST_POP) && (sp_q != '0);
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      stk_p_q[STK_IW'(sp_q)]  <= push_p;
      stk_l_q[STK_IW'(sp_q)]  <= push_l;
      stk_r_q[STK_IW'(sp_q)]  <= push_r;
      stk_ph_q[STK_IW'(sp_q)] <= push_ph;
    end
  end

  logic [STK_IW-1:0] top_w;
  assign top_w = STK_IW'(sp_q - SP_W'(1));

  // memories and merge unit
  logic              val_we, node_we, merge_start, merge_done;
  logic [POS_W-1:0]  val_waddr;
  logic [VAL_W-1:0]  val_wdata, val_rdata;
  logic [NODE_W-1:0] node_waddr, node_raddr;
  agg_t              node_wdata, node_rdata, merge_a, merge_c;

  always_comb begin
    if (state_q == ST_CLEAR) begin
      val_we    = (32'(clr_q) < MAX_ELEMENTS);
      val_waddr = POS_W'(clr_q);
      val_wdata = '0;
    end else begin
      val_we    = accept && (mode_w == MODE_LOAD) && (val_masked != '0) &&
                  (32'(in_i.index) < MAX_ELEMENTS);
      val_waddr = POS_W'(in_i.index);
      val_wdata = val_masked;
    end

    node_we    = 1'b0;
    node_waddr = cur_p_q;
    node_wdata = merge_c;
    case (state_q)
      ST_CLEAR: begin
        node_we    = 1'b1;
        node_waddr = clr_q;
        node_wdata = EMPTY_AGG;
      end
      ST_LEAF: begin
        node_we    = 1'b1;
        node_wdata = '{empty: 1'b0, mx: val_rdata, mn: val_rdata, drop: '0, rn: '0,
                       rd: VAL_W'(1)};
      end
      ST_MRG: node_we = build_q && merge_done;
      default: ;
    endcase

    case (state_q)
      ST_VISIT: node_raddr = build_q ? lc_w : cur_p_q;
      ST_RD_R:  node_raddr = rc_w;
      default:  node_raddr = cur_p_q;
    endcase

    merge_start = (state_q == ST_NODE) && (build_q || !node_rdata.empty);
    merge_a     = build_q ? ma_q : acc_q;
  end

  rmdq_mem #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_mem (
    .clk_i        (clk_i),
    .val_we_i     (val_we),
    .val_waddr_i  (val_waddr),
    .val_wdata_i  (val_wdata),
    .val_raddr_i  (cur_l_q),
    .val_rdata_o  (val_rdata),
    .node_we_i    (node_we),
    .node_waddr_i (node_waddr),
    .node_wdata_i (node_wdata),
    .node_raddr_i (node_raddr),
    .node_rdata_o (node_rdata)
  );

  rmdq_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (merge_start),
    .a_i     (merge_a),
    .b_i     (node_rdata),
    .done_o  (merge_done),
    .c_o     (merge_c)
  );

  // handshake outputs
  assign in_i.ready        = (state_q == ST_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = out_valid_q;
  assign out_o.max_drop    = out_drop_q;
  assign out_o.ratio_num   = out_rn_q;
  assign out_o.ratio_den   = out_rd_q;
  assign out_o.range_error = out_err_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      count_q     <= CNT_W'(1);
      sp_q        <= '0;
      build_q     <= 1'b0;
      cur_p_q     <= '0;
      cur_l_q     <= '0;
      cur_r_q     <= '0;
      cur_ph_q    <= 1'b0;
      qa_q        <= '0;
      qb_q        <= '0;
      acc_q       <= EMPTY_AGG;
      ma_q        <= EMPTY_AGG;
      res_drop_q  <= '0;
      res_rn_q    <= '0;
      res_rd_q    <= VAL_W'(1);
      res_err_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_drop_q  <= '0;
      out_rn_q    <= '0;
      out_rd_q    <= VAL_W'(1);
      out_err_q   <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        count_q <= cfg_i.data;
      end
      if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (push_en) begin
        sp_q <= sp_q + SP_W'(1);
      end else if (pop_en) begin
        sp_q <= sp_q - SP_W'(1);
      end

      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + NODE_W'(1);
          if (clr_q == NODE_W'(NODES - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            qa_q  <= in_i.left;
            qb_q  <= in_i.right;
            acc_q <= EMPTY_AGG;
            case (mode_w)
              MODE_LOAD: begin
                if (val_masked == '0) begin
                  res_drop_q <= '0;
                  res_rn_q   <= '0;
                  res_rd_q   <= VAL_W'(1);
                  res_err_q  <= 1'b1;
                  state_q    <= ST_EMIT;
                end
              end
              MODE_BUILD: begin
                build_q <= 1'b1;
                state_q <= ST_POP;
              end
              MODE_QUERY: begin
                build_q <= 1'b0;
                if (bad_range) begin
                  res_drop_q <= '0;
                  res_rn_q   <= '0;
                  res_rd_q   <= VAL_W'(1);
                  res_err_q  <= 1'b1;
                  state_q    <= ST_EMIT;
                end else begin
                  state_q <= ST_POP;
                end
              end
              default: ;
            endcase
          end
        end
        ST_POP: begin
          if (sp_q == '0) begin
            res_drop_q <= acc_q.empty ? '0 : acc_q.drop;
            res_rn_q   <= acc_q.empty ? '0 : acc_q.rn;
            res_rd_q   <= acc_q.empty ? VAL_W'(1) : acc_q.rd;
            res_err_q  <= 1'b0;
            state_q    <= build_q ? ST_IDLE : ST_EMIT;
          end else begin
            cur_p_q  <= stk_p_q[top_w];
            cur_l_q  <= stk_l_q[top_w];
            cur_r_q  <= stk_r_q[top_w];
            cur_ph_q <= stk_ph_q[top_w];
            state_q  <= ST_VISIT;
          end
        end
        ST_VISIT: begin
          if (build_q) begin
            if (cur_l_q == cur_r_q) begin
              state_q <= ST_LEAF;
            end else if (!cur_ph_q) begin
              state_q <= ST_PUSH_R;
            end else begin
              state_q <= ST_RD_R;
            end
          end else if (covered) begin
            state_q <= ST_NODE;
          end else if (disjoint || cur_l_q == cur_r_q) begin
            state_q <= ST_POP;
          end else begin
            state_q <= ST_PUSH_R;
          end
        end
        ST_PUSH_R: state_q <= ST_PUSH_L;
        ST_PUSH_L: state_q <= ST_POP;
        ST_LEAF:   state_q <= ST_POP;
        ST_RD_R: begin
          ma_q    <= node_rdata;
          state_q <= ST_NODE;
        end
        // an empty covered node adds nothing to the running result
        ST_NODE:   state_q <= merge_start ? ST_MRG : ST_POP;
        ST_MRG: begin
          if (merge_done) begin
            if (!build_q) begin
              acc_q <= merge_c;
            end
            state_q <= ST_POP;
          end
        end
        ST_EMIT: begin
          if (!out_valid_q || out_o.ready) begin
            out_drop_q  <= res_drop_q;
            out_rn_q    <= res_rn_q;
            out_rd_q    <= res_rd_q;
            out_err_q   <= res_err_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // checks
  `RMDQ_ASSERT_NEVER(a_stack_ovf, clk_i, rst_ni, push_en && (sp_q == SP_W'(STACK_D)))
  `RMDQ_ASSERT(a_merge_done, clk_i, rst_ni, merge_done |-> (state_q == ST_MRG))
  `RMDQ_ASSERT(a_den_nonzero, clk_i, rst_ni, out_valid_q |-> (out_rd_q != '0))

endmodule
`default_nettype wire
